[sv/tci_pkg.sv]
// Shared codes and field widths for the tone curve table interpolator.
`timescale 1ns / 1ps
package tci_pkg;
  localparam int unsigned PIX_W  = 24;
  localparam int unsigned GAIN_W = 24;
  localparam int unsigned WP_W   = 20;
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned ROW_W  = 64;

  localparam logic [1:0] MODE_PIXEL  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [2:0] ST_MAPPED  = 3'd0;
  localparam logic [2:0] ST_STORED  = 3'd1;
  localparam logic [2:0] ST_DROPPED = 3'd2;
  localparam logic [2:0] ST_CLEARED = 3'd3;
  localparam logic [2:0] ST_BLACK   = 3'd4;

  localparam logic CFG_EXPOSURE = 1'b0;
  localparam logic CFG_WHITE    = 1'b1;

  localparam logic [15:0] VAL_MAX = 16'hFFFF;
endpackage

[sv/tone_curve_table_interpolator_top.sv]
// Piecewise-linear tone curve: response table in one memory, shared serial divider.
// Pixel item, per channel: scale by exposure, divide by white point, binary search of
// the knots (up to ceil(log2(rows - 1)) steps), two row reads and product, divide and
// clamp; a saturated channel skips the rest and a zero-width segment skips the divide.
// Append, clear and black items pass straight to the output.
// One item at a time, set by the one-bit-a-cycle divider and the single table read port.
// Reset clears control and row count and sets exposure and white point to 65536; table contents stay undefined.
`timescale 1ns / 1ps
module tone_curve_table_interpolator_top #(
  parameter int unsigned ENTRIES = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pixel_red, pixel_green, pixel_blue, knot_irradiance, knot_red, knot_green, knot_blue
  input  logic [135:0] s_axis_tdata,
  // mode
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_red, out_green, out_blue
  output logic [47:0]  m_axis_tdata,
  // status
  output logic [2:0]   m_axis_tuser,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [23:0]  cfg_data_i
);
  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] FULL = CW'(ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL0, S_MUL1, S_SAT, S_DIV1, S_VSET, S_SRCH, S_CMP,
    S_RD0, S_RD1, S_RD2, S_MUL2, S_DPREP, S_DIV2, S_INTERP, S_DONE
  } state_e;

  state_e        state_q;
  logic [23:0]   exp_q;
  logic [19:0]   wp_q;
  logic [CW-1:0] cnt_q;
  logic [23:0]   pix_q [3];
  logic [15:0]   res_q [3];
  logic [1:0]    ch_q;
  logic [2:0]    status_q;
  logic          ovalid_q;
  logic [47:0]   odata_q;
  logic [2:0]    ostat_q;
  logic [47:0]   prod_q;
  logic [47:0]   dd_q;
  logic [19:0]   rem_q, dvsr_q;
  logic [5:0]    step_q;
  logic [15:0]   v_q;
  logic [CW-1:0] size_q, first_q, mid_q;
  logic [AW-1:0] idx_q;
  logic [63:0]   row0_q, row1_q;
  logic signed [33:0] num_q;
  logic signed [16:0] den_q;
  logic          neg_q;

  logic [63:0]   mem [ENTRIES];
  logic [63:0]   rd_q;
  logic [AW-1:0] rd_addr;
  logic          wr_en;

  logic          in_acc, out_acc, out_free;
  logic [23:0]   pix;
  logic [35:0]   pp;
  logic [19:0]   divz;
  logic [20:0]   r2;
  logic          ge;
  logic [CW-1:0] half, mid, idx_raw;
  logic [15:0]   k0, k1, y0, y1;
  logic signed [17:0] dv;
  logic signed [16:0] dy, den;
  logic signed [34:0] num;
  logic [31:0]   absnum;
  logic signed [33:0] yv;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_acc  = m_axis_tvalid && m_axis_tready;
  assign out_free = !ovalid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ostat_q;
  assign wr_en = in_acc && !s_axis_tuser[1] && (s_axis_tuser == tci_pkg::MODE_APPEND)
                 && (cnt_q < FULL);

  // Datapath helpers for the current channel
  always_comb begin
    pix  = pix_q[ch_q];
    pp   = pix * exp_q[11:0];
    if (state_q == S_MUL1) pp = pix * exp_q[23:12];
    divz = (wp_q == '0) ? 20'd1 : wp_q;
    r2   = {rem_q, dd_q[47]};
    ge   = (r2 >= {1'b0, dvsr_q});
    half = size_q >> 1;
    mid  = first_q + half;
    idx_raw = first_q - CW'(1);
    if (idx_raw > cnt_q - CW'(2)) idx_raw = cnt_q - CW'(2);
    k0 = row0_q[15:0];
    k1 = row1_q[15:0];
    y0 = row0_q[16*ch_q+16 +: 16];
    y1 = row1_q[16*ch_q+16 +: 16];
    dv  = $signed({2'b0, v_q}) - $signed({2'b0, k0});
    dy  = $signed({1'b0, y1}) - $signed({1'b0, y0});
    den = $signed({1'b0, k1}) - $signed({1'b0, k0});
    num = dv * dy;
    absnum = num_q[33] ? 32'(-num_q) : 32'(num_q);
    yv = neg_q ? $signed({18'b0, y0}) - $signed({2'b0, dd_q[31:0]})
               : $signed({18'b0, y0}) + $signed({2'b0, dd_q[31:0]});
    rd_addr = mid[AW-1:0];
    if (state_q == S_RD0) rd_addr = idx_q;
    if (state_q == S_RD1) rd_addr = idx_q + AW'(1);
  end

  // Table memory: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[cnt_q[AW-1:0]] <= s_axis_tdata[135:72];
    rd_q <= mem[rd_addr];
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= 24'd65536;
      wp_q  <= 20'd65536;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == tci_pkg::CFG_EXPOSURE) exp_q <= cfg_data_i;
      if (cfg_idx_i == tci_pkg::CFG_WHITE)    wp_q  <= cfg_data_i[19:0];
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
      odata_q  <= '0;
      ostat_q  <= tci_pkg::ST_MAPPED;
      ch_q     <= '0;
      status_q <= tci_pkg::ST_MAPPED;
    end else begin
      // Drop a taken result; in S_DONE a taken result is replaced below
      if (out_acc && (state_q != S_DONE)) ovalid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            pix_q[0] <= s_axis_tdata[23:0];
            pix_q[1] <= s_axis_tdata[47:24];
            pix_q[2] <= s_axis_tdata[71:48];
            for (int i = 0; i < 3; i++) res_q[i] <= '0;
            ch_q    <= '0;
            state_q <= S_DONE;
            if (s_axis_tuser[1]) begin
              cnt_q    <= '0;
              status_q <= tci_pkg::ST_CLEARED;
            end else if (s_axis_tuser == tci_pkg::MODE_APPEND) begin
              if (cnt_q < FULL) begin
                cnt_q    <= cnt_q + CW'(1);
                status_q <= tci_pkg::ST_STORED;
              end else begin
                status_q <= tci_pkg::ST_DROPPED;
              end
            end else if (cnt_q < CW'(2)) begin
              status_q <= tci_pkg::ST_BLACK;
            end else begin
              status_q <= tci_pkg::ST_MAPPED;
              state_q  <= S_MUL0;
            end
          end
        end
        S_MUL0: begin
          prod_q  <= {12'b0, pp};
          state_q <= S_MUL1;
        end
        S_MUL1: begin
          prod_q  <= prod_q + {pp, 12'b0};
          state_q <= S_SAT;
        end
        S_SAT: begin
          if (prod_q[47:16] >= {12'b0, divz}) begin
            res_q[ch_q] <= tci_pkg::VAL_MAX;
            state_q     <= S_INTERP;
            neg_q       <= 1'b0;
            step_q      <= '1;
          end else begin
            rem_q   <= prod_q[35:16];
            dd_q    <= {prod_q[15:0], 32'b0};
            dvsr_q  <= divz;
            step_q  <= 6'd16;
            state_q <= S_DIV1;
          end
        end
        S_DIV1, S_DIV2: begin
          rem_q  <= ge ? 20'(r2 - {1'b0, dvsr_q}) : r2[19:0];
          dd_q   <= {dd_q[46:0], ge};
          step_q <= step_q - 6'd1;
          if (step_q == 6'd1) state_q <= (state_q == S_DIV1) ? S_VSET : S_INTERP;
        end
        S_VSET: begin
          v_q     <= dd_q[15:0];
          size_q  <= cnt_q - CW'(2);
          first_q <= CW'(1);
          state_q <= S_SRCH;
        end
        S_SRCH: begin
          if (size_q == '0) begin
            idx_q   <= idx_raw[AW-1:0];
            state_q <= S_RD0;
          end else begin
            mid_q   <= mid;
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          if (rd_q[15:0] <= v_q) begin
            first_q <= mid_q + CW'(1);
            size_q  <= size_q - half - CW'(1);
          end else begin
            size_q  <= half;
          end
          state_q <= S_SRCH;
        end
        S_RD0: state_q <= S_RD1;
        S_RD1: begin
          row0_q  <= rd_q;
          state_q <= S_RD2;
        end
        S_RD2: begin
          row1_q  <= rd_q;
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          num_q <= 34'(num);
          den_q <= den;
          if (k1 == k0) begin
            res_q[ch_q] <= y0;
            neg_q       <= 1'b0;
            step_q      <= '1;
            state_q     <= S_INTERP;
          end else begin
            state_q <= S_DPREP;
          end
        end
        S_DPREP: begin
          dd_q    <= {absnum, 16'b0};
          rem_q   <= '0;
          dvsr_q  <= {4'b0, den_q[16] ? 16'(-den_q) : 16'(den_q)};
          neg_q   <= num_q[33] ^ den_q[16];
          step_q  <= 6'd32;
          state_q <= S_DIV2;
        end
        S_INTERP: begin
          // step_q at zero marks a finished interpolation; otherwise the
          // channel result was already written
          if (step_q == '0) begin
            if (yv < 0) res_q[ch_q] <= '0;
            else if (yv > 34'sd65535) res_q[ch_q] <= tci_pkg::VAL_MAX;
            else res_q[ch_q] <= yv[15:0];
          end
          if (ch_q == 2'd2) begin
            state_q <= S_DONE;
          end else begin
            ch_q    <= ch_q + 2'd1;
            state_q <= S_MUL0;
          end
        end
        S_DONE: begin
          // Hold until the output register is free, then load it
          if (out_free) begin
            ovalid_q <= 1'b1;
            odata_q  <= {res_q[2], res_q[1], res_q[0]};
            ostat_q  <= status_q;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Row count never passes the table depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= FULL)
    else $error("row count above depth");
  // Table writes happen only on an accepted append
  a_wr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> state_q == S_IDLE)
    else $error("table write outside idle");
  // Search window stays inside the stored rows
  a_srch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SRCH |-> (first_q + size_q <= cnt_q - CW'(1)) && (first_q != '0))
    else $error("search window out of table");
  // A finished result is not overwritten before it is taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("pending result lost");
endmodule
